// File: hdl/blwd_pkg.sv
// Shared types and constants for the bounded list with delete by value.
package blwd_pkg;

	localparam int CAP   = 16;
	localparam int IDX_W = $clog2(CAP);
	localparam int CNT_W = $clog2(CAP + 1);
	localparam int VAL_W = 32;

	typedef enum logic [1:0] {
		FUNC_APPEND       = 2'd0,
		FUNC_REMOVE_HEAD  = 2'd1,
		FUNC_REMOVE_MATCH = 2'd2,
		FUNC_SIZE         = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_FULL      = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_UPDATE
	} state_t;

	typedef struct packed {
		func_t                    func;
		logic signed [VAL_W-1:0]  operand_value;
	} req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0]  removed_value;
		status_t                  status;
		logic [4:0]               entry_count;
	} rsp_t;

	typedef struct packed {
		logic capture;
		logic search;
		logic update;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_status_t;

endpackage

// File: hdl/blwd_ctrl.sv
// Controller state machine: sequences capture, search and update of one request.
module blwd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  blwd_pkg::dp_status_t dp_status,
	output blwd_pkg::cmd_t      cmd
);
	import blwd_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_SEARCH;
				end
			end
			S_SEARCH: begin
				cmd.search = 1'b1;
				state_d    = S_UPDATE;
			end
			S_UPDATE: begin
				// The result can only be loaded once the output register has room.
				if (dp_status.out_free) begin
					cmd.update = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// File: hdl/blwd_dpath.sv
// Datapath: list cells with per-cell compare, count, request and result registers.
module blwd_dpath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  blwd_pkg::req_t       req,
	input  blwd_pkg::cmd_t       cmd,
	output blwd_pkg::dp_status_t dp_status,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output blwd_pkg::rsp_t       rsp
);
	import blwd_pkg::*;

	logic [VAL_W-1:0] entries_q [CAP];
	logic [CNT_W-1:0] count_q;
	req_t             req_q;
	logic [CAP-1:0]   match_s1;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic [CAP-1:0]   match_d;
	logic [CAP-1:0]   first_hot;
	logic [CAP-1:0]   shift_mask;
	logic [VAL_W-1:0] pick_val;
	logic             is_full;
	logic             is_empty;
	logic             do_remove;
	logic             do_append;
	status_t          status_d;
	logic [CNT_W-1:0] count_d;

	// Every cell compares against the captured operand, limited to live entries.
	always_comb begin
		for (int i = 0; i < CAP; i++) begin
			match_d[i] = (entries_q[i] == req_q.operand_value) &&
				(CNT_W'(i) < count_q);
		end
	end

	assign is_full  = (count_q == CNT_W'(CAP));
	assign is_empty = (count_q == '0);

	always_comb begin
		do_remove = 1'b0;
		do_append = 1'b0;
		status_d  = ST_DONE;
		first_hot = '0;
		case (req_q.func)
			FUNC_APPEND: begin
				if (is_full) begin
					status_d = ST_FULL;
				end else begin
					do_append = 1'b1;
				end
			end
			FUNC_REMOVE_HEAD: begin
				if (is_empty) begin
					status_d = ST_EMPTY;
				end else begin
					do_remove = 1'b1;
					first_hot = CAP'(1);
				end
			end
			FUNC_REMOVE_MATCH: begin
				if (is_empty) begin
					status_d = ST_EMPTY;
				end else if (match_s1 == '0) begin
					status_d = ST_NOT_FOUND;
				end else begin
					do_remove = 1'b1;
					// Isolate the oldest matching cell.
					first_hot = match_s1 & (~match_s1 + CAP'(1));
				end
			end
			default: begin
				status_d = ST_DONE;
			end
		endcase
	end

	// Cells at and above the removed position take their upper neighbor.
	assign shift_mask = ~(first_hot - CAP'(1));

	always_comb begin
		pick_val = '0;
		for (int i = 0; i < CAP; i++) begin
			pick_val = pick_val | (first_hot[i] ? entries_q[i] : '0);
		end
	end

	always_comb begin
		count_d = count_q;
		if (do_append) begin
			count_d = count_q + CNT_W'(1);
		end else if (do_remove) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
		if (cmd.search) begin
			match_s1 <= match_d;
		end
		if (cmd.update) begin
			rsp_q.removed_value <= do_remove ? pick_val : '0;
			rsp_q.status        <= status_d;
			rsp_q.entry_count   <= 5'(count_d);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update && do_remove) begin
			for (int i = 0; i < CAP - 1; i++) begin
				if (shift_mask[i]) begin
					entries_q[i] <= entries_q[i+1];
				end
			end
		end else if (cmd.update && do_append) begin
			entries_q[count_q[IDX_W-1:0]] <= req_q.operand_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.update) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign dp_status.out_free = !rsp_valid_q || !rsp_stall;
	assign rsp_valid          = rsp_valid_q;
	assign rsp                = rsp_q;

endmodule

// File: hdl/bounded_list_with_delete.sv
// Top level of the bounded ordered list with delete by value.
//
//   channel | direction | payload | handshake
//   req     | in        | req_t   | req_valid / req_stall
//   rsp     | out       | rsp_t   | rsp_valid / rsp_stall
//
// Each request passes through capture, a registered compare in all
// sixteen cells, then the update that shifts the cells and loads the result.
// A new request is taken in the cycle after the update, so requests are
// handled one at a time; a stalled result holds the update step until the
// register frees.
// Reset clears the count and the control state; the cells are not cleared.
module bounded_list_with_delete (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  blwd_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output blwd_pkg::rsp_t rsp
);
	import blwd_pkg::*;

	cmd_t       cmd;
	dp_status_t dp_status;

	blwd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.dp_status (dp_status),
		.cmd       (cmd)
	);

	blwd_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.dp_status (dp_status),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// File: hdl/blwd_checker.sv
// Port-level checks for the bounded list, bound to the top level.
module blwd_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input blwd_pkg::rsp_t rsp
);
	import blwd_pkg::*;

	// A stalled result stays offered.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("result dropped while stalled");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.entry_count <= 5'(CAP))
		else $error("entry count above capacity");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_FULL |-> rsp.entry_count == 5'(CAP))
		else $error("full status with room left");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_EMPTY |-> rsp.entry_count == '0)
		else $error("empty status with entries stored");

	// Only a successful removal may carry a nonzero value.
	a_removed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.removed_value != '0 |-> rsp.status == ST_DONE)
		else $error("removed value on a failed request");

endmodule

bind bounded_list_with_delete blwd_checker u_blwd_checker (.*);
